FILE: sv/sual_pkg.sv
package sual_pkg;

  // table sizes
  localparam int NUM_DOFS      = 1024;
  localparam int NUM_EQUATIONS = 1024;
  localparam int NUM_SLOTS     = 8192;

  // address and data widths; PTR_W and VAL_W are fixed, the rest are derived
  localparam int DOF_W  = $clog2(NUM_DOFS);
  localparam int EQ_W   = $clog2(NUM_EQUATIONS);
  localparam int CS_W   = $clog2(NUM_EQUATIONS + 1);
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int ROW_W  = EQ_W + 1;
  localparam int PTR_W  = 15;
  localparam int VAL_W  = 32;

  // action codes
  typedef enum logic [2:0] {
    ACT_MAP_DOF    = 3'd0,
    ACT_COL_START  = 3'd1,
    ACT_SLOT_ROW   = 3'd2,
    ACT_WRITE_SLOT = 3'd3,
    ACT_ACCUM      = 3'd4,
    ACT_READ_SLOT  = 3'd5
  } action_t;

  // result status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_CONSTR = 2'd1;
  localparam logic [1:0] ST_LOWER  = 2'd2;
  localparam logic [1:0] ST_NO_ROW = 2'd3;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EQ     = 8'b0000_0010,
    S_COL    = 8'b0000_0100,
    S_SROW   = 8'b0000_1000,
    S_SCMP   = 8'b0001_0000,
    S_ADD_RE = 8'b0010_0000,
    S_ADD_IM = 8'b0100_0000,
    S_RD     = 8'b1000_0000
  } state_t;

endpackage

FILE: sv/sual_sat_add.sv
module sual_sat_add (
  input  logic signed [sual_pkg::VAL_W-1:0] a,
  input  logic signed [sual_pkg::VAL_W-1:0] b,
  output logic signed [sual_pkg::VAL_W-1:0] sum,
  output logic                              clip
);

  logic signed [sual_pkg::VAL_W:0] wide;

  // one extra bit catches overflow
  assign wide = {a[sual_pkg::VAL_W-1], a} + {b[sual_pkg::VAL_W-1], b};

  // clamp to the signed limits
  always_comb begin
    clip = (wide[sual_pkg::VAL_W] != wide[sual_pkg::VAL_W-1]);
    if (!clip) begin
      sum = wide[sual_pkg::VAL_W-1:0];
    end else if (wide[sual_pkg::VAL_W]) begin
      sum = {1'b1, {(sual_pkg::VAL_W-1){1'b0}}};
    end else begin
      sum = {1'b0, {(sual_pkg::VAL_W-1){1'b1}}};
    end
  end

endmodule

FILE: sv/sparse_upper_assembly_accumulator.sv
// channel  | handshake      | word
// ---------+----------------+-----------------------------------------------------
// command  | start, busy    | action, dof_row, dof_col, index, load_data, value_re/im
// result   | done (strobe)  | status, saturated, out_re, out_im
//
// Loads, slot writes and unused actions answer in the next cycle and may follow
// one another every cycle. A slot read answers from the read state. An accumulate
// answers from the equation state on a skip, else reads the column starts, then
// compares one slot row at a time; a miss answers, a match does the real then the
// imaginary add; the slot-row memory port and one saturating adder are shared.
// Reset (rst, synchronous) clears only the sequencer and the strobe; tables hold
// garbage until loaded. The receiver cannot stall: done lasts one cycle.
module sparse_upper_assembly_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic [9:0]         dof_row,
  input  logic [9:0]         dof_col,
  input  logic [13:0]        index,
  input  logic signed [14:0] load_data,
  input  logic signed [31:0] value_re,
  input  logic signed [31:0] value_im,
  output logic               done,
  output logic [1:0]         status,
  output logic               saturated,
  output logic signed [31:0] out_re,
  output logic signed [31:0] out_im
);

  sual_pkg::state_t  state;
  sual_pkg::action_t act;
  logic              accept;

  // memories
  logic [sual_pkg::EQ_W:0]          dmap_mem [sual_pkg::NUM_DOFS];
  logic signed [sual_pkg::PTR_W-1:0] cs_mem  [sual_pkg::NUM_EQUATIONS + 1];
  logic [sual_pkg::ROW_W-1:0]       srow_mem [sual_pkg::NUM_SLOTS];
  logic signed [sual_pkg::VAL_W-1:0] sre_mem [sual_pkg::NUM_SLOTS];
  logic signed [sual_pkg::VAL_W-1:0] sim_mem [sual_pkg::NUM_SLOTS];

  // memory read data
  logic [sual_pkg::EQ_W:0]           dmap_rd_r;
  logic [sual_pkg::EQ_W:0]           dmap_rd_c;
  logic signed [sual_pkg::PTR_W-1:0] cs_rd_lo;
  logic signed [sual_pkg::PTR_W-1:0] cs_rd_hi;
  logic [sual_pkg::ROW_W-1:0]        srow_rd;
  logic signed [sual_pkg::VAL_W-1:0] sre_rd;
  logic signed [sual_pkg::VAL_W-1:0] sim_rd;

  // memory control
  logic                              dmap_we;
  logic                              ld_constr;
  logic                              cs_we;
  logic                              srow_we;
  logic [sual_pkg::ROW_W-1:0]        srow_wd;
  logic                              sv_we;
  logic [sual_pkg::SLOT_W-1:0]       sv_wa;
  logic signed [sual_pkg::VAL_W-1:0] sre_wd;
  logic signed [sual_pkg::VAL_W-1:0] sim_wd;
  logic [sual_pkg::SLOT_W-1:0]       sv_ra;
  logic [sual_pkg::CS_W-1:0]         cs_ra_lo;
  logic [sual_pkg::CS_W-1:0]         cs_ra_hi;

  // item registers
  logic signed [sual_pkg::VAL_W-1:0] vre;
  logic signed [sual_pkg::VAL_W-1:0] vim;
  logic                              rd_ok;
  logic                              row_bad;
  logic                              col_bad;
  logic [sual_pkg::EQ_W-1:0]         er;
  logic signed [sual_pkg::PTR_W-1:0] m;
  logic signed [sual_pkg::PTR_W-1:0] m_dec;
  logic signed [sual_pkg::PTR_W-1:0] stop;
  logic [sual_pkg::SLOT_W-1:0]       slot_m;
  logic signed [sual_pkg::VAL_W-1:0] sum_re;
  logic                              clip_re;

  // search and equation decode
  logic                              eq_r_con;
  logic                              eq_c_con;
  logic                              m_in_range;
  logic                              m_more;
  logic                              row_hit;

  // shared adder
  logic signed [sual_pkg::VAL_W-1:0] add_a;
  logic signed [sual_pkg::VAL_W-1:0] add_b;
  logic signed [sual_pkg::VAL_W-1:0] add_sum;
  logic                              add_clip;

  assign busy   = (state != sual_pkg::S_IDLE);
  assign accept = start && !busy;
  assign act    = sual_pkg::action_t'(action);

  // load decode
  assign ld_constr = load_data[sual_pkg::PTR_W-1] ||
                     (int'(load_data) >= sual_pkg::NUM_EQUATIONS);
  assign dmap_we = accept && (act == sual_pkg::ACT_MAP_DOF) &&
                   (int'(index) < sual_pkg::NUM_DOFS);
  assign cs_we   = accept && (act == sual_pkg::ACT_COL_START) &&
                   (int'(index) < sual_pkg::NUM_EQUATIONS + 1);
  assign srow_we = accept && (act == sual_pkg::ACT_SLOT_ROW) &&
                   (int'(index) < sual_pkg::NUM_SLOTS);
  // rows outside the equation range store zero, which never matches
  assign srow_wd = ((int'(load_data) >= 1) && (int'(load_data) <= sual_pkg::NUM_EQUATIONS)) ?
                   sual_pkg::ROW_W'(load_data) : '0;

  // slot address from the 1-based search pointer
  assign m_dec  = m - sual_pkg::PTR_W'(1);
  assign slot_m = sual_pkg::SLOT_W'(m_dec);

  // slot value port muxing
  assign sv_we  = (accept && (act == sual_pkg::ACT_WRITE_SLOT) &&
                   (int'(index) < sual_pkg::NUM_SLOTS)) ||
                  (state == sual_pkg::S_ADD_IM);
  assign sv_wa  = (state == sual_pkg::S_ADD_IM) ? slot_m : sual_pkg::SLOT_W'(index);
  assign sre_wd = (state == sual_pkg::S_ADD_IM) ? sum_re : value_re;
  assign sim_wd = (state == sual_pkg::S_ADD_IM) ? add_sum : value_im;
  assign sv_ra  = busy ? slot_m : sual_pkg::SLOT_W'(index);

  // column start addresses follow the column equation
  assign cs_ra_lo = sual_pkg::CS_W'(dmap_rd_c[sual_pkg::EQ_W-1:0]);
  assign cs_ra_hi = cs_ra_lo + sual_pkg::CS_W'(1);

  // equation and search decode
  assign eq_r_con   = row_bad || dmap_rd_r[sual_pkg::EQ_W];
  assign eq_c_con   = col_bad || dmap_rd_c[sual_pkg::EQ_W];
  assign m_in_range = (m >= sual_pkg::PTR_W'(1)) && (int'(m) <= sual_pkg::NUM_SLOTS);
  assign m_more     = (m < stop);
  assign row_hit    = (srow_rd == (sual_pkg::ROW_W'(er) + sual_pkg::ROW_W'(1)));

  // dof map memory
  always_ff @(posedge clk) begin
    if (dmap_we) begin
      dmap_mem[sual_pkg::DOF_W'(index)] <= {ld_constr, sual_pkg::EQ_W'(load_data)};
    end
    dmap_rd_r <= dmap_mem[sual_pkg::DOF_W'(dof_row)];
    dmap_rd_c <= dmap_mem[sual_pkg::DOF_W'(dof_col)];
  end

  // column start memory
  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[sual_pkg::CS_W'(index)] <= load_data;
    end
    cs_rd_lo <= cs_mem[cs_ra_lo];
    cs_rd_hi <= cs_mem[cs_ra_hi];
  end

  // slot row memory
  always_ff @(posedge clk) begin
    if (srow_we) begin
      srow_mem[sual_pkg::SLOT_W'(index)] <= srow_wd;
    end
    srow_rd <= srow_mem[slot_m];
  end

  // slot value memories
  always_ff @(posedge clk) begin
    if (sv_we) begin
      sre_mem[sv_wa] <= sre_wd;
      sim_mem[sv_wa] <= sim_wd;
    end
    sre_rd <= sre_mem[sv_ra];
    sim_rd <= sim_mem[sv_ra];
  end

  // shared saturating adder, real part first then imaginary
  assign add_a = (state == sual_pkg::S_ADD_IM) ? sim_rd : sre_rd;
  assign add_b = (state == sual_pkg::S_ADD_IM) ? vim : vre;

  sual_sat_add u_add (
    .a    (add_a),
    .b    (add_b),
    .sum  (add_sum),
    .clip (add_clip)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sual_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        sual_pkg::S_IDLE: begin
          if (accept) begin
            case (act)
              sual_pkg::ACT_ACCUM: begin
                state <= sual_pkg::S_EQ;
              end
              sual_pkg::ACT_READ_SLOT: begin
                state <= sual_pkg::S_RD;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        sual_pkg::S_EQ: begin
          if (eq_r_con || eq_c_con ||
              (dmap_rd_c[sual_pkg::EQ_W-1:0] < dmap_rd_r[sual_pkg::EQ_W-1:0])) begin
            done  <= 1'b1;
            state <= sual_pkg::S_IDLE;
          end else begin
            state <= sual_pkg::S_COL;
          end
        end
        sual_pkg::S_COL: begin
          state <= sual_pkg::S_SROW;
        end
        sual_pkg::S_SROW: begin
          if (!m_more || !m_in_range) begin
            done  <= 1'b1;
            state <= sual_pkg::S_IDLE;
          end else begin
            state <= sual_pkg::S_SCMP;
          end
        end
        sual_pkg::S_SCMP: begin
          state <= row_hit ? sual_pkg::S_ADD_RE : sual_pkg::S_SROW;
        end
        sual_pkg::S_ADD_RE: begin
          state <= sual_pkg::S_ADD_IM;
        end
        sual_pkg::S_ADD_IM: begin
          done  <= 1'b1;
          state <= sual_pkg::S_IDLE;
        end
        sual_pkg::S_RD: begin
          done  <= 1'b1;
          state <= sual_pkg::S_IDLE;
        end
        default: begin
          state <= sual_pkg::S_IDLE;
        end
      endcase
    end
  end

  // datapath and result word
  always_ff @(posedge clk) begin
    case (state)
      sual_pkg::S_IDLE: begin
        vre     <= value_re;
        vim     <= value_im;
        rd_ok   <= (int'(index) < sual_pkg::NUM_SLOTS);
        row_bad <= (int'(dof_row) >= sual_pkg::NUM_DOFS);
        col_bad <= (int'(dof_col) >= sual_pkg::NUM_DOFS);
        status    <= sual_pkg::ST_DONE;
        saturated <= 1'b0;
        if (act == sual_pkg::ACT_WRITE_SLOT && int'(index) < sual_pkg::NUM_SLOTS) begin
          out_re <= value_re;
          out_im <= value_im;
        end else begin
          out_re <= '0;
          out_im <= '0;
        end
      end
      sual_pkg::S_EQ: begin
        er <= dmap_rd_r[sual_pkg::EQ_W-1:0];
        if (eq_r_con || eq_c_con) begin
          status <= sual_pkg::ST_CONSTR;
        end else begin
          status <= sual_pkg::ST_LOWER;
        end
      end
      sual_pkg::S_COL: begin
        m    <= cs_rd_lo;
        stop <= cs_rd_hi;
      end
      sual_pkg::S_SROW: begin
        status <= sual_pkg::ST_NO_ROW;
      end
      sual_pkg::S_SCMP: begin
        if (!row_hit) begin
          m <= m + sual_pkg::PTR_W'(1);
        end
      end
      sual_pkg::S_ADD_RE: begin
        sum_re  <= add_sum;
        clip_re <= add_clip;
      end
      sual_pkg::S_ADD_IM: begin
        status    <= sual_pkg::ST_DONE;
        saturated <= clip_re || add_clip;
        out_re    <= sum_re;
        out_im    <= add_sum;
      end
      sual_pkg::S_RD: begin
        out_re <= rd_ok ? sre_rd : '0;
        out_im <= rd_ok ? sim_rd : '0;
      end
      default: begin
        status <= sual_pkg::ST_DONE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // an accumulate always enters the sequencer
  a_accum_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (action == sual_pkg::ACT_ACCUM) |=> busy)
    else $error("accumulate did not start the sequencer");

  // a skip or a miss returns zero values
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != sual_pkg::ST_DONE) |-> (out_re == '0) && (out_im == '0))
    else $error("skip result carries a value");

  // clipping is only reported on a completed add
  a_sat_done: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> (status == sual_pkg::ST_DONE))
    else $error("saturated flag on a non-add result");

  // slot compare only looks at slots inside the table
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == sual_pkg::S_SCMP) |-> m_in_range && m_more)
    else $error("slot search left its range");
`endif

endmodule
